[rtl/nvme_queue_pair_tracker_assert.svh]
// Assertion macros of the queue pair tracker, used by nqpt_core.
// Needs nothing but a clock and an active-high reset at the point of use.
`ifndef NVME_QUEUE_PAIR_TRACKER_ASSERT_SVH
`define NVME_QUEUE_PAIR_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define NQPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NQPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/nqpt_pkg.sv]
// Types, codes and constants of the NVMe queue pair tracker.
// Used by every module of the block; depends on nothing.
package nqpt_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;

   localparam int TAG_W    = 16;
   localparam int WORD_W   = 32;
   localparam int SLOT_W   = 5;
   localparam int OFFSET_W = 34;
   localparam int SCODE_W  = 15;
   localparam int STRIDE_W = 4;
   localparam int LIMIT_W  = 32;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 112;

   localparam logic [OFFSET_W-1:0] DB_BASE     = OFFSET_W'(34'h1000);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 32'd40000000;
   localparam logic [TAG_W-1:0]    TAG_FIRST   = 16'd1;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_POLL   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_SUBMITTED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WAITING   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_STRIDE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUEUE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT  = 2'd2;

   typedef struct packed {
      logic             command;
      logic [TAG_W-1:0] opcode_word;
      logic [TAG_W-1:0] entry_status;
      logic [TAG_W-1:0] entry_tag;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [WORD_W-1:0]   command_word;
      logic [TAG_W-1:0]    assigned_tag;
      logic [SLOT_W-1:0]   slot_index;
      logic [OFFSET_W-1:0] doorbell_offset;
      logic [SLOT_W-1:0]   doorbell_value;
      logic [SCODE_W-1:0]  status_code;
   } rsp_item_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] tail_offset;
      logic [OFFSET_W-1:0] head_offset;
      logic [LIMIT_W-1:0]  poll_limit;
   } cfg_type;

endpackage

[rtl/nvme_queue_pair_tracker.sv]
// Top level of the NVMe queue pair tracker: input stage, result register, glue.
// Depends on nqpt_pkg, nqpt_csr and nqpt_core.
//
//   channel  dir  transfer                   payload
//   req_     in   req_tvalid & req_tready    tdata {entry_tag, entry_status, opcode_word}
//                                            tuser command
//   rsp_     out  rsp_tvalid & rsp_tready    tdata result fields, tuser result_kind
//   csr_     in   csr_valid & csr_ready      csr_index, csr_data
//
// One transaction per cycle unless rsp_ stalls; req_ is held in the input register,
// which feeds the state update and result logic in one pass into the rsp_ result register.
// A stalled rsp_ holds one result while one more request waits in the input stage.
// Reset is synchronous; configuration writes are always taken (csr_ready high).
module nvme_queue_pair_tracker
   import nqpt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] opcode_word, [31:16] entry_status, [47:32] entry_tag
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] command_word, [47:32] assigned_tag, [52:48] slot_index,
   // [86:53] doorbell_offset, [91:87] doorbell_value, [106:92] status_code, zero above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] result_kind
   output logic [KIND_W-1:0]     rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   cfg_type      cfg;
   logic         advance;
   logic         req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.command      <= req_tuser;
         in_item_ff.opcode_word  <= req_tdata[15:0];
         in_item_ff.entry_status <= req_tdata[31:16];
         in_item_ff.entry_tag    <= req_tdata[47:32];
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   nqpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   nqpt_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.result_kind;
   assign rsp_tdata  = {5'd0,
                        out_item_ff.status_code,
                        out_item_ff.doorbell_value,
                        out_item_ff.doorbell_offset,
                        out_item_ff.slot_index,
                        out_item_ff.assigned_tag,
                        out_item_ff.command_word};

endmodule

[rtl/nqpt_csr.sv]
// Configuration registers and doorbell offset decode of the queue pair tracker.
// Depends on nqpt_pkg.
module nqpt_csr
   import nqpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [STRIDE_W-1:0] stride_ff;
   logic [TAG_W-1:0]    queue_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                write;
   logic [4:0]          shift;
   logic [16:0]         tail_idx;
   logic [16:0]         head_idx;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= '0;
         queue_ff  <= '0;
         limit_ff  <= LIMIT_RESET;
      end else if (write) begin
         unique case (csr_index)
            REG_STRIDE: stride_ff <= csr_data[STRIDE_W-1:0];
            REG_QUEUE:  queue_ff  <= csr_data[TAG_W-1:0];
            REG_LIMIT:  limit_ff  <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // spacing is 4 bytes shifted left by the stride
   assign shift    = {1'b0, stride_ff} + 5'd2;
   assign tail_idx = {queue_ff, 1'b0};
   assign head_idx = {queue_ff, 1'b1};

   assign cfg.tail_offset = DB_BASE + (OFFSET_W'(tail_idx) << shift);
   assign cfg.head_offset = DB_BASE + (OFFSET_W'(head_idx) << shift);
   assign cfg.poll_limit  = limit_ff;

endmodule

[rtl/nqpt_core.sv]
// Queue pair state and per-transaction result logic of the tracker.
// Depends on nqpt_pkg and the assertion macro header.
`include "nvme_queue_pair_tracker_assert.svh"

module nqpt_core
   import nqpt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [PTR_W-1:0]   sub_tail_ff,    sub_tail_in;
   logic [PTR_W-1:0]   comp_head_ff,   comp_head_in;
   logic               phase_ff,       phase_in;
   logic [TAG_W-1:0]   next_tag_ff,    next_tag_in;
   logic [TAG_W-1:0]   awaited_tag_ff, awaited_tag_in;
   logic               awaiting_ff,    awaiting_in;
   logic [LIMIT_W-1:0] poll_count_ff,  poll_count_in;

   logic [PTR_W-1:0]   tail_step;
   logic [PTR_W-1:0]   head_step;
   logic [TAG_W-1:0]   tag_step;
   logic [LIMIT_W-1:0] count_step;
   logic               match;

   assign tail_step  = (sub_tail_ff == PTR_LAST) ? '0 : sub_tail_ff + PTR_W'(1);
   assign head_step  = (comp_head_ff == PTR_LAST) ? '0 : comp_head_ff + PTR_W'(1);
   assign tag_step   = (next_tag_ff == '1) ? TAG_FIRST : next_tag_ff + TAG_W'(1);
   assign count_step = (poll_count_ff == '1) ? poll_count_ff
                                              : poll_count_ff + LIMIT_W'(1);
   assign match      = (item.entry_status[0] == phase_ff)
                       && (item.entry_tag == awaited_tag_ff);

   always_comb begin
      sub_tail_in    = sub_tail_ff;
      comp_head_in   = comp_head_ff;
      phase_in       = phase_ff;
      next_tag_in    = next_tag_ff;
      awaited_tag_in = awaited_tag_ff;
      awaiting_in    = awaiting_ff;
      poll_count_in  = poll_count_ff;
      result         = '0;
      result.result_kind = KIND_WAITING;
      priority if (item.command == CMD_SUBMIT) begin
         next_tag_in         = tag_step;
         sub_tail_in         = tail_step;
         awaited_tag_in      = next_tag_ff;
         awaiting_in         = 1'b1;
         poll_count_in       = '0;
         result.result_kind  = KIND_SUBMITTED;
         result.command_word = {next_tag_ff, item.opcode_word};
         result.assigned_tag = next_tag_ff;
         result.slot_index   = SLOT_W'(sub_tail_ff);
         result.doorbell_offset = cfg.tail_offset;
         result.doorbell_value  = SLOT_W'(tail_step);
      end else if (awaiting_ff && match) begin
         comp_head_in  = head_step;
         phase_in      = (head_step == '0) ? ~phase_ff : phase_ff;
         awaiting_in   = 1'b0;
         poll_count_in = '0;
         result.result_kind     = KIND_ACCEPTED;
         result.doorbell_offset = cfg.head_offset;
         result.doorbell_value  = SLOT_W'(head_step);
         result.status_code     = item.entry_status[TAG_W-1:1];
      end else if (awaiting_ff) begin
         if (count_step >= cfg.poll_limit) begin
            awaiting_in        = 1'b0;
            poll_count_in      = '0;
            result.result_kind = KIND_TIMEOUT;
         end else begin
            poll_count_in = count_step;
         end
      end else begin
         result.result_kind = KIND_WAITING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_tail_ff    <= '0;
         comp_head_ff   <= '0;
         phase_ff       <= 1'b1;
         next_tag_ff    <= TAG_FIRST;
         awaited_tag_ff <= '0;
         awaiting_ff    <= 1'b0;
         poll_count_ff  <= '0;
      end else if (fire) begin
         sub_tail_ff    <= sub_tail_in;
         comp_head_ff   <= comp_head_in;
         phase_ff       <= phase_in;
         next_tag_ff    <= next_tag_in;
         awaited_tag_ff <= awaited_tag_in;
         awaiting_ff    <= awaiting_in;
         poll_count_ff  <= poll_count_in;
      end
   end

   `NQPT_ASSERT_NOW(a_tag_nonzero, clock, reset, 1'b1, next_tag_ff != '0,
      "command identifier counter reached zero")
   `NQPT_ASSERT_NOW(a_ptr_range, clock, reset, 1'b1,
      (sub_tail_ff <= PTR_LAST) && (comp_head_ff <= PTR_LAST),
      "queue pointer beyond depth")
   `NQPT_ASSERT_NOW(a_idle_count, clock, reset, !awaiting_ff, poll_count_ff == '0,
      "poll count held with no command outstanding")
   `NQPT_ASSERT_NEXT(a_submit_awaits, clock, reset, fire && item.command == CMD_SUBMIT,
      awaiting_ff && (awaited_tag_ff == $past(next_tag_ff)),
      "submitted identifier not awaited")
   `NQPT_ASSERT_NOW(a_idle_poll, clock, reset,
      fire && item.command == CMD_POLL && !awaiting_ff,
      result.result_kind == KIND_WAITING,
      "poll with nothing outstanding did not report waiting")

endmodule
